FILE: sv/ssp_pkg.sv
package ssp_pkg;

    localparam int CMD_W    = 3;
    localparam int DATA_IN_W = 32;
    localparam int HB_W     = 3;
    localparam int HS_W     = 6;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 56;
    localparam int CFG_W    = 7;
    localparam int SKIP_W   = 8;
    localparam int MIN_SIZE = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT     = 3'd0,
        CMD_ERASE      = 3'd1,
        CMD_GET        = 3'd2,
        CMD_WALK_BEGIN = 3'd3,
        CMD_WALK_NEXT  = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    typedef enum logic [4:0] {
        S_SWEEP_INIT,
        S_IDLE,
        S_DISPATCH,
        S_FIND,
        S_POP_RD,
        S_POP_TAKE,
        S_FWD_RD,
        S_FWD_CHK,
        S_SKIP_SET,
        S_BWD_RD,
        S_BWD_CHK,
        S_CHK_RD,
        S_CHK,
        S_WALK_BEGIN,
        S_WALK_RD,
        S_WALK_CHK,
        S_SWEEP_CLR,
        S_RESEED,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_SWEEP,
        OP_RESEED,
        OP_FIND_STEP,
        OP_OPEN,
        OP_POP_RD,
        OP_POP_TAKE,
        OP_FWD_RD,
        OP_FWD_ADV,
        OP_FWD_HIT,
        OP_FWD_END,
        OP_SKIP_SET,
        OP_BWD_RD,
        OP_BWD_HIT,
        OP_CHK_RD,
        OP_ERASE,
        OP_GET,
        OP_WALK_START,
        OP_WALK_RD,
        OP_WALK_ADV,
        OP_WALK_YIELD,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        cmd_t cmd;
        logic find_hit;
        logic find_end;
        logic can_open;
        logic fwd_end;
        logic bwd_end;
        logic skip_nz;
        logic handle_ok;
        logic walk_end;
        logic wrem_zero;
        logic live_zero;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: sv/ssp_ram.sv
module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/ssp_ctrl.sv
module ssp_ctrl
    import ssp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       cfg_valid,
    input  dp_status_t st,
    output dp_op_t     op,
    output logic       s_tready,
    output logic       cfg_ready
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_SWEEP_INIT:
            begin
                op = OP_SWEEP;
                if (st.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    op         = OP_INIT;
                    state_next = S_SWEEP_INIT;
                end
                else if (s_tvalid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.cmd)
                    CMD_INSERT:     state_next = S_FIND;
                    CMD_ERASE:      state_next = S_CHK_RD;
                    CMD_GET:        state_next = S_CHK_RD;
                    CMD_WALK_BEGIN: state_next = S_WALK_BEGIN;
                    CMD_WALK_NEXT:  state_next = st.wrem_zero ? S_DONE : S_WALK_RD;
                    CMD_CLEAR:      state_next = S_SWEEP_CLR;
                    default:        state_next = S_DONE;
                endcase
            end
            S_FIND:
            begin
                if (st.find_hit)
                begin
                    op         = OP_POP_RD;
                    state_next = S_POP_TAKE;
                end
                else if (!st.find_end)
                begin
                    op = OP_FIND_STEP;
                end
                else if (st.can_open)
                begin
                    op         = OP_OPEN;
                    state_next = S_POP_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_POP_RD:
            begin
                op         = OP_POP_RD;
                state_next = S_POP_TAKE;
            end
            S_POP_TAKE:
            begin
                op         = OP_POP_TAKE;
                state_next = S_FWD_RD;
            end
            S_FWD_RD:
            begin
                if (st.fwd_end)
                begin
                    op         = OP_FWD_END;
                    state_next = S_SKIP_SET;
                end
                else
                begin
                    op         = OP_FWD_RD;
                    state_next = S_FWD_CHK;
                end
            end
            S_FWD_CHK:
            begin
                if (st.skip_nz)
                begin
                    op         = OP_FWD_HIT;
                    state_next = S_SKIP_SET;
                end
                else
                begin
                    op         = OP_FWD_ADV;
                    state_next = S_FWD_RD;
                end
            end
            S_SKIP_SET:
            begin
                op         = OP_SKIP_SET;
                state_next = S_BWD_RD;
            end
            S_BWD_RD:
            begin
                if (st.bwd_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    op         = OP_BWD_RD;
                    state_next = S_BWD_CHK;
                end
            end
            S_BWD_CHK:
            begin
                if (st.skip_nz)
                begin
                    op         = OP_BWD_HIT;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_BWD_RD;
                end
            end
            S_CHK_RD:
            begin
                if (st.handle_ok)
                begin
                    op         = OP_CHK_RD;
                    state_next = S_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_CHK:
            begin
                if (!st.skip_nz)
                begin
                    state_next = S_DONE;
                end
                else if (st.cmd == CMD_GET)
                begin
                    op         = OP_GET;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = OP_ERASE;
                    state_next = S_FWD_RD;
                end
            end
            S_WALK_BEGIN:
            begin
                op         = OP_WALK_START;
                state_next = st.live_zero ? S_DONE : S_WALK_RD;
            end
            S_WALK_RD:
            begin
                if (st.walk_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    op         = OP_WALK_RD;
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                if (!st.skip_nz)
                begin
                    op         = OP_WALK_ADV;
                    state_next = S_WALK_RD;
                end
                else
                begin
                    if (st.cmd == CMD_WALK_NEXT)
                    begin
                        op = OP_WALK_YIELD;
                    end
                    state_next = S_DONE;
                end
            end
            S_SWEEP_CLR:
            begin
                op = OP_SWEEP;
                if (st.sweep_last)
                begin
                    state_next = S_RESEED;
                end
            end
            S_RESEED:
            begin
                op         = OP_RESEED;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/ssp_datapath.sv
module ssp_datapath
    import ssp_pkg::*;
#(
    parameter int MAX_BLOCKS  = 8,
    parameter int BLOCK_SLOTS = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dp_op_t           op,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [OUT_W-1:0] m_tdata,
    output dp_status_t       st
);

    localparam int TOTAL      = MAX_BLOCKS * BLOCK_SLOTS;
    localparam int ADDR_W     = $clog2(TOTAL);
    localparam int BLK_W      = $clog2(MAX_BLOCKS + 1);
    localparam int BIDX_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int SLOT_W     = $clog2(BLOCK_SLOTS + 1);
    localparam int SIDX_W     = $clog2(BLOCK_SLOTS);
    localparam int LIVE_W     = $clog2(TOTAL + 1);
    localparam int RESET_SIZE = (BLOCK_SLOTS < 64) ? BLOCK_SLOTS : 64;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [BLK_W-1:0] b,
                                                  input logic [SLOT_W-1:0] s);
        return ADDR_W'(ADDR_W'(b) * ADDR_W'(BLOCK_SLOTS) + ADDR_W'(s));
    endfunction

    function automatic logic [SLOT_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
        logic [SLOT_W-1:0] r;
        if (8'(v) < 8'(MIN_SIZE))
        begin
            r = SLOT_W'(MIN_SIZE);
        end
        else if (8'(v) > 8'(BLOCK_SLOTS))
        begin
            r = SLOT_W'(BLOCK_SLOTS);
        end
        else
        begin
            r = SLOT_W'(v);
        end
        return r;
    endfunction

    logic [SLOT_W-1:0]     bs_reg, bs_next;
    logic [BLK_W-1:0]      fill_reg, fill_next;
    logic [LIVE_W-1:0]     live_reg, live_next;
    logic [SIDX_W-1:0]     head_reg [MAX_BLOCKS];
    logic [SIDX_W-1:0]     head_next [MAX_BLOCKS];
    logic [SLOT_W-1:0]     hw_reg [MAX_BLOCKS];
    logic [SLOT_W-1:0]     hw_next [MAX_BLOCKS];
    logic [SLOT_W-1:0]     left_reg [MAX_BLOCKS];
    logic [SLOT_W-1:0]     left_next [MAX_BLOCKS];
    logic [BLK_W-1:0]      wb_reg, wb_next;
    logic [SIDX_W-1:0]     ws_reg, ws_next;
    logic [LIVE_W-1:0]     wrem_reg, wrem_next;
    logic [BLK_W-1:0]      cur_b_reg, cur_b_next;
    logic [SIDX_W-1:0]     cur_s_reg, cur_s_next;
    logic [SLOT_W-1:0]     pos_reg, pos_next;
    logic [SLOT_W-1:0]     nxt_reg, nxt_next;
    logic [ADDR_W-1:0]     sweep_reg, sweep_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [HB_W-1:0]       hb_reg, hb_next;
    logic [HS_W-1:0]       hs_reg, hs_next;
    logic                  res_ok_reg, res_ok_next;
    logic [BLK_W-1:0]      res_b_reg, res_b_next;
    logic [SIDX_W-1:0]     res_s_reg, res_s_next;
    logic [DATA_WIDTH-1:0] res_d_reg, res_d_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]      m_tdata_reg, m_tdata_next;

    logic                  skip_we, skip_re, slot_we, slot_re;
    logic [ADDR_W-1:0]     skip_waddr, skip_raddr, slot_waddr, slot_raddr;
    logic [SKIP_W-1:0]     skip_wdata, skip_rdata;
    logic [DATA_WIDTH-1:0] slot_wdata, slot_rdata;

    logic [BIDX_W-1:0]     cb;
    logic [SIDX_W-1:0]     pop_s;
    logic [SLOT_W-1:0]     pop_s1;
    logic [SLOT_W-1:0]     fresh_link;
    logic [SLOT_W-1:0]     bwd_target;
    logic [8:0]            ws_jump;
    logic [SLOT_W-1:0]     ws_inc;
    logic                  is_insert;

    assign cb         = cur_b_reg[BIDX_W-1:0];
    assign pop_s      = head_reg[cb];
    assign pop_s1     = SLOT_W'(pop_s) + SLOT_W'(1);
    assign fresh_link = (pop_s1 < bs_reg) ? pop_s1 : '0;
    assign is_insert  = (cmd_reg == CMD_INSERT);
    assign bwd_target = is_insert ? SLOT_W'(cur_s_reg) : nxt_reg;
    assign ws_jump    = 9'(ws_reg) + 9'(skip_rdata);
    assign ws_inc     = SLOT_W'(ws_reg) + SLOT_W'(1);

    ssp_ram #(.WIDTH(SKIP_W), .DEPTH(TOTAL)) u_skip_ram (
        .clk   (clk),
        .we    (skip_we),
        .waddr (skip_waddr),
        .wdata (skip_wdata),
        .re    (skip_re),
        .raddr (skip_raddr),
        .rdata (skip_rdata)
    );

    ssp_ram #(.WIDTH(DATA_WIDTH), .DEPTH(TOTAL)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    always_comb
    begin
        skip_we    = 1'b0;
        skip_waddr = '0;
        skip_wdata = '0;
        skip_re    = 1'b0;
        skip_raddr = '0;
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        slot_re    = 1'b0;
        slot_raddr = '0;
        case (op)
            OP_SWEEP:
            begin
                skip_we    = 1'b1;
                skip_waddr = sweep_reg;
            end
            OP_POP_RD:
            begin
                slot_re    = 1'b1;
                slot_raddr = addr_of(cur_b_reg, SLOT_W'(pop_s));
            end
            OP_POP_TAKE:
            begin
                slot_we    = 1'b1;
                slot_waddr = addr_of(cur_b_reg, SLOT_W'(pop_s));
                slot_wdata = data_reg;
            end
            OP_FWD_RD:
            begin
                skip_re    = 1'b1;
                skip_raddr = addr_of(cur_b_reg, pos_reg);
            end
            OP_SKIP_SET:
            begin
                skip_we    = 1'b1;
                skip_waddr = addr_of(cur_b_reg, SLOT_W'(cur_s_reg));
                skip_wdata = is_insert ? SKIP_W'(nxt_reg - SLOT_W'(cur_s_reg)) : '0;
            end
            OP_BWD_RD:
            begin
                skip_re    = 1'b1;
                skip_raddr = addr_of(cur_b_reg, pos_reg - SLOT_W'(1));
            end
            OP_BWD_HIT:
            begin
                skip_we    = 1'b1;
                skip_waddr = addr_of(cur_b_reg, pos_reg);
                skip_wdata = SKIP_W'(bwd_target - pos_reg);
            end
            OP_CHK_RD:
            begin
                skip_re    = 1'b1;
                skip_raddr = addr_of(BLK_W'(hb_reg), SLOT_W'(hs_reg));
                slot_re    = 1'b1;
                slot_raddr = addr_of(BLK_W'(hb_reg), SLOT_W'(hs_reg));
            end
            OP_ERASE:
            begin
                slot_we    = 1'b1;
                slot_waddr = addr_of(cur_b_reg, SLOT_W'(cur_s_reg));
                slot_wdata = DATA_WIDTH'(head_reg[cb]);
            end
            OP_WALK_RD:
            begin
                skip_re    = 1'b1;
                skip_raddr = addr_of(wb_reg, SLOT_W'(ws_reg));
                slot_re    = 1'b1;
                slot_raddr = addr_of(wb_reg, SLOT_W'(ws_reg));
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        logic [DATA_WIDTH-1:0] link;
        logic [SLOT_W-1:0]     new_size;
        bs_next       = bs_reg;
        fill_next     = fill_reg;
        live_next     = live_reg;
        head_next     = head_reg;
        hw_next       = hw_reg;
        left_next     = left_reg;
        wb_next       = wb_reg;
        ws_next       = ws_reg;
        wrem_next     = wrem_reg;
        cur_b_next    = cur_b_reg;
        cur_s_next    = cur_s_reg;
        pos_next      = pos_reg;
        nxt_next      = nxt_reg;
        sweep_next    = sweep_reg;
        cmd_next      = cmd_reg;
        data_next     = data_reg;
        hb_next       = hb_reg;
        hs_next       = hs_reg;
        res_ok_next   = res_ok_reg;
        res_b_next    = res_b_reg;
        res_s_next    = res_s_reg;
        res_d_next    = res_d_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        link          = (SLOT_W'(pop_s) < hw_reg[cb]) ? slot_rdata
                                                      : DATA_WIDTH'(fresh_link);
        new_size      = clamp_size(cfg_data);
        case (op)
            OP_LOAD:
            begin
                cmd_next    = cmd_t'(s_tdata[2:0]);
                data_next   = DATA_WIDTH'(s_tdata[34:3]);
                hb_next     = s_tdata[37:35];
                hs_next     = s_tdata[43:38];
                cur_b_next  = '0;
                sweep_next  = '0;
                res_ok_next = 1'b0;
                res_b_next  = '0;
                res_s_next  = '0;
                res_d_next  = '0;
            end
            OP_INIT:
            begin
                bs_next      = new_size;
                fill_next    = BLK_W'(1);
                live_next    = '0;
                wb_next      = '0;
                ws_next      = '0;
                wrem_next    = '0;
                sweep_next   = '0;
                head_next[0] = '0;
                hw_next[0]   = '0;
                left_next[0] = new_size;
            end
            OP_SWEEP:
            begin
                sweep_next = sweep_reg + ADDR_W'(1);
            end
            OP_RESEED:
            begin
                for (int b = 0; b < MAX_BLOCKS; b++)
                begin
                    if (8'(b) < 8'(fill_reg))
                    begin
                        head_next[b] = '0;
                        hw_next[b]   = '0;
                        left_next[b] = bs_reg;
                    end
                end
                live_next   = '0;
                res_ok_next = 1'b1;
            end
            OP_FIND_STEP:
            begin
                cur_b_next = cur_b_reg + BLK_W'(1);
            end
            OP_OPEN:
            begin
                head_next[cb] = '0;
                hw_next[cb]   = '0;
                left_next[cb] = bs_reg;
                fill_next     = fill_reg + BLK_W'(1);
            end
            OP_POP_TAKE:
            begin
                head_next[cb] = (link < DATA_WIDTH'(bs_reg)) ? SIDX_W'(link) : '0;
                if (SLOT_W'(pop_s) == hw_reg[cb])
                begin
                    hw_next[cb] = pop_s1;
                end
                left_next[cb] = left_reg[cb] - SLOT_W'(1);
                live_next     = live_reg + LIVE_W'(1);
                cur_s_next    = pop_s;
                pos_next      = pop_s1;
                res_ok_next   = 1'b1;
                res_b_next    = cur_b_reg;
                res_s_next    = pop_s;
            end
            OP_FWD_ADV:
            begin
                pos_next = pos_reg + SLOT_W'(1);
            end
            OP_FWD_HIT:
            begin
                nxt_next = pos_reg;
            end
            OP_FWD_END:
            begin
                nxt_next = bs_reg;
            end
            OP_SKIP_SET:
            begin
                pos_next = SLOT_W'(cur_s_reg);
            end
            OP_BWD_RD:
            begin
                pos_next = pos_reg - SLOT_W'(1);
            end
            OP_CHK_RD:
            begin
                cur_b_next = BLK_W'(hb_reg);
                cur_s_next = SIDX_W'(hs_reg);
            end
            OP_ERASE:
            begin
                head_next[cb] = cur_s_reg;
                left_next[cb] = left_reg[cb] + SLOT_W'(1);
                live_next     = live_reg - LIVE_W'(1);
                pos_next      = SLOT_W'(cur_s_reg) + SLOT_W'(1);
                res_ok_next   = 1'b1;
            end
            OP_GET:
            begin
                res_ok_next = 1'b1;
                res_d_next  = slot_rdata;
            end
            OP_WALK_START:
            begin
                wb_next     = '0;
                ws_next     = '0;
                wrem_next   = live_reg;
                res_ok_next = 1'b1;
            end
            OP_WALK_ADV:
            begin
                if (ws_inc >= bs_reg)
                begin
                    wb_next = wb_reg + BLK_W'(1);
                    ws_next = '0;
                end
                else
                begin
                    ws_next = SIDX_W'(ws_inc);
                end
            end
            OP_WALK_YIELD:
            begin
                res_ok_next = 1'b1;
                res_b_next  = wb_reg;
                res_s_next  = ws_reg;
                res_d_next  = slot_rdata;
                wrem_next   = wrem_reg - LIVE_W'(1);
                if (ws_jump >= 9'(bs_reg))
                begin
                    wb_next = wb_reg + BLK_W'(1);
                    ws_next = '0;
                end
                else
                begin
                    ws_next = SIDX_W'(ws_jump);
                end
            end
            OP_EMIT:
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {4'(fill_reg), 10'(live_reg), 32'(res_d_reg),
                                 6'(res_s_reg), 3'(res_b_reg), res_ok_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg       <= SLOT_W'(RESET_SIZE);
            fill_reg     <= BLK_W'(1);
            live_reg     <= '0;
            for (int b = 0; b < MAX_BLOCKS; b++)
            begin
                head_reg[b] <= '0;
                hw_reg[b]   <= '0;
                left_reg[b] <= (b == 0) ? SLOT_W'(RESET_SIZE) : '0;
            end
            wb_reg       <= '0;
            ws_reg       <= '0;
            wrem_reg     <= '0;
            cur_b_reg    <= '0;
            sweep_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            bs_reg       <= bs_next;
            fill_reg     <= fill_next;
            live_reg     <= live_next;
            head_reg     <= head_next;
            hw_reg       <= hw_next;
            left_reg     <= left_next;
            wb_reg       <= wb_next;
            ws_reg       <= ws_next;
            wrem_reg     <= wrem_next;
            cur_b_reg    <= cur_b_next;
            sweep_reg    <= sweep_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_s_reg   <= cur_s_next;
        pos_reg     <= pos_next;
        nxt_reg     <= nxt_next;
        cmd_reg     <= cmd_next;
        data_reg    <= data_next;
        hb_reg      <= hb_next;
        hs_reg      <= hs_next;
        res_ok_reg  <= res_ok_next;
        res_b_reg   <= res_b_next;
        res_s_reg   <= res_s_next;
        res_d_reg   <= res_d_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        st.cmd        = cmd_reg;
        st.find_hit   = (cur_b_reg < fill_reg) && (left_reg[cb] != '0);
        st.find_end   = (cur_b_reg >= fill_reg);
        st.can_open   = (8'(fill_reg) < 8'(MAX_BLOCKS));
        st.fwd_end    = (pos_reg >= bs_reg);
        st.bwd_end    = (pos_reg == '0);
        st.skip_nz    = (skip_rdata != '0);
        st.handle_ok  = (8'(hb_reg) < 8'(fill_reg)) && (8'(hs_reg) < 8'(bs_reg));
        st.walk_end   = (wb_reg >= fill_reg);
        st.wrem_zero  = (wrem_reg == '0);
        st.live_zero  = (live_reg == '0);
        st.sweep_last = (sweep_reg == ADDR_W'(TOTAL - 1));
        st.out_free   = !m_tvalid_reg || m_tready;
    end

endmodule

FILE: sv/skipfield_slot_pool.sv
// Slot pool of up to MAX_BLOCKS blocks of slots holding data words. Each
// block threads a LIFO free list through its dead slots and keeps a skipfield
// in which a live slot holds the distance to the next live slot. One command
// beat on s_* gives exactly one result beat on m_*; the block works on one
// command at a time. Insert and erase scan the skip memory forward to the
// next live slot and backward to the previous one; insert also steps over
// full blocks, and walk begin/next step over dead slots one at a time. Clear
// zeroes the skip memory one entry per cycle. Unless a block_size write
// waits, s_tready rises together with the result beat's m_tvalid, so the
// next command beat can be taken while the result waits. After reset and
// after every block_size write the same clearing pass runs with s_tready
// low. Write cfg_data only while no command is in flight.
module skipfield_slot_pool
    import ssp_pkg::*;
#(
    parameter int MAX_BLOCKS  = 8,
    parameter int BLOCK_SLOTS = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    // command beat
    input  logic             s_tvalid,
    output logic             s_tready,
    // cmd[2:0], data_value[34:3], block_index[37:35], slot_index[43:38]
    input  logic [IN_W-1:0]  s_tdata,
    // result beat
    output logic             m_tvalid,
    input  logic             m_tready,
    // ok[0], out_block[3:1], out_slot[9:4], out_data[41:10],
    // live_total[51:42], blocks_open[55:52]
    output logic [OUT_W-1:0] m_tdata,
    // block_size write
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    dp_op_t     op;
    dp_status_t st;

    // sequencer: steps through scans, pops and the clearing pass
    ssp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .cfg_valid (cfg_valid),
        .st        (st),
        .op        (op),
        .s_tready  (s_tready),
        .cfg_ready (cfg_ready)
    );

    // stores, free-list heads, walk position and result register
    ssp_datapath #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_SLOTS (BLOCK_SLOTS),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .s_tdata  (s_tdata),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .st       (st)
    );

endmodule

FILE: sv/ssp_checker.sv
module ssp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [6:0]  cfg_data
);

    // never take a command and a config write in the same cycle
    a_no_dual_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tvalid && s_tready && cfg_valid && cfg_ready))
        else $error("command and config accepted together");

    // one command at a time: hold off the next beat after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready && !cfg_ready)
        else $error("input ready right after accept");

    // a failed result carries a zero handle
    a_fail_zero_handle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[9:1] == 9'd0))
        else $error("failed result with nonzero handle");

    // at least one block always open
    a_blocks_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[55:52] != 4'd0))
        else $error("no open block reported");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind skipfield_slot_pool ssp_checker u_ssp_checker (.*);

FILE: tb/tb_skipfield_slot_pool.sv
`timescale 1ns / 100ps

// Scoreboard: owns a behavioral copy of the slot pool and a queue of expected
// result beats. note_command() advances the copy for one accepted command beat;
// check_result() compares one accepted result beat with the oldest expectation.
class pool_scoreboard;
    localparam int NBLK  = 8;
    localparam int NSLOT = 64;

    typedef struct packed {
        logic        ok;
        logic [2:0]  blk;
        logic [5:0]  slot;
        logic [31:0] data;
        logic [9:0]  live;
        logic [3:0]  open;
    } result_t;

    logic [31:0] slot_mem [NBLK*NSLOT];
    logic [7:0]  skip_mem [NBLK*NSLOT];
    int unsigned head [NBLK];
    int unsigned left [NBLK];
    int unsigned fill, live_cnt, wblk, wslot, wrem, bsize;
    result_t     pending[$];
    int          errors;

    function new();
        errors = 0;
        bsize  = 64;
        reinit();
    endfunction

    function void seed(int unsigned b);
        for (int unsigned i = 0; i < bsize; i++) begin
            slot_mem[b*NSLOT+i] = (i + 1 < bsize) ? i + 1 : 0;
            skip_mem[b*NSLOT+i] = 0;
        end
        head[b] = 0;
        left[b] = bsize;
    endfunction

    function void reinit();
        for (int i = 0; i < NBLK*NSLOT; i++)
        begin
            slot_mem[i] = 0;
            skip_mem[i] = 0;
        end
        for (int i = 0; i < NBLK; i++)
        begin
            head[i] = 0;
            left[i] = 0;
        end
        fill = 1; live_cnt = 0; wblk = 0; wslot = 0; wrem = 0;
        seed(0);
    endfunction

    function void set_size(logic [6:0] v);
        bsize = (v < 16) ? 16 : (v > NSLOT) ? NSLOT : v;
        reinit();
    endfunction

    function int unsigned next_live(int unsigned b, int unsigned from);
        for (int unsigned i = from; i < bsize; i++)
            if (skip_mem[b*NSLOT+i] != 0) return i;
        return bsize;
    endfunction

    function int prev_live(int unsigned b, int unsigned s);
        for (int i = int'(s) - 1; i >= 0; i--)
            if (skip_mem[b*NSLOT+i] != 0) return i;
        return -1;
    endfunction

    function void note_command(logic [47:0] beat);
        logic [2:0]  cmd;
        logic [31:0] dv;
        int unsigned hb, hs, b, s, lnk;
        int          p;
        result_t     r;
        cmd = beat[2:0];
        dv  = beat[34:3];
        hb  = beat[37:35];
        hs  = beat[43:38];
        r   = '0;
        case (cmd)
            ssp_pkg::CMD_INSERT:
            begin
                for (b = 0; b < fill; b++)
                    if (left[b] != 0) break;
                if (b >= fill && fill < NBLK)
                begin
                    b = fill;
                    seed(b);
                    fill++;
                end
                if (b < fill && left[b] != 0)
                begin
                    s = head[b];
                    if (s >= bsize) s = 0;
                    lnk = slot_mem[b*NSLOT+s];
                    slot_mem[b*NSLOT+s] = dv;
                    head[b] = (lnk < bsize) ? lnk : 0;
                    left[b]--;
                    live_cnt++;
                    skip_mem[b*NSLOT+s] = next_live(b, s + 1) - s;
                    p = prev_live(b, s);
                    if (p >= 0) skip_mem[b*NSLOT+p] = s - p;
                    r.ok = 1; r.blk = b; r.slot = s;
                end
            end
            ssp_pkg::CMD_ERASE, ssp_pkg::CMD_GET:
            begin
                if (hb < fill && hs < bsize && skip_mem[hb*NSLOT+hs] != 0)
                begin
                    r.ok = 1;
                    if (cmd == ssp_pkg::CMD_GET)
                        r.data = slot_mem[hb*NSLOT+hs];
                    else
                    begin
                        slot_mem[hb*NSLOT+hs] = head[hb];
                        skip_mem[hb*NSLOT+hs] = 0;
                        head[hb] = hs;
                        left[hb]++;
                        live_cnt--;
                        p = prev_live(hb, hs);
                        if (p >= 0) skip_mem[hb*NSLOT+p] = next_live(hb, hs + 1) - p;
                    end
                end
            end
            ssp_pkg::CMD_WALK_BEGIN:
            begin
                wblk = 0; wslot = 0; wrem = live_cnt;
                while (wrem > 0 && wblk < fill)
                begin
                    s = next_live(wblk, 0);
                    if (s < bsize)
                    begin
                        wslot = s;
                        break;
                    end
                    wblk++;
                    wslot = 0;
                end
                r.ok = 1;
            end
            ssp_pkg::CMD_WALK_NEXT:
            begin
                if (wrem != 0)
                    while (wblk < fill)
                    begin
                        if (wslot < bsize && skip_mem[wblk*NSLOT+wslot] != 0)
                        begin
                            r.ok = 1; r.blk = wblk; r.slot = wslot;
                            r.data = slot_mem[wblk*NSLOT+wslot];
                            wrem--;
                            wslot += skip_mem[wblk*NSLOT+wslot];
                            if (wslot >= bsize)
                            begin
                                wblk++;
                                wslot = 0;
                            end
                            break;
                        end
                        wslot++;
                        if (wslot >= bsize)
                        begin
                            wblk++;
                            wslot = 0;
                        end
                    end
            end
            ssp_pkg::CMD_CLEAR:
            begin
                for (int unsigned i = 0; i < fill; i++) seed(i);
                live_cnt = 0;
                r.ok = 1;
            end
            default: ;
        endcase
        r.live = live_cnt;
        r.open = fill;
        pending.push_back(r);
    endfunction

    function void check_result(logic [55:0] beat);
        result_t e, a;
        a = {beat[0], beat[3:1], beat[9:4], beat[41:10], beat[51:42], beat[55:52]};
        if (pending.size() == 0)
        begin
            $error("unexpected result beat %h", beat);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a.ok !== e.ok)
        begin
            $error("ok: expected %0d actual %0d", e.ok, a.ok);
            errors++;
        end
        if (a.blk !== e.blk)
        begin
            $error("out_block: expected %0d actual %0d", e.blk, a.blk);
            errors++;
        end
        if (a.slot !== e.slot)
        begin
            $error("out_slot: expected %0d actual %0d", e.slot, a.slot);
            errors++;
        end
        if (a.data !== e.data)
        begin
            $error("out_data: expected %h actual %h", e.data, a.data);
            errors++;
        end
        if (a.live !== e.live)
        begin
            $error("live_total: expected %0d actual %0d", e.live, a.live);
            errors++;
        end
        if (a.open !== e.open)
        begin
            $error("blocks_open: expected %0d actual %0d", e.open, a.open);
            errors++;
        end
    endfunction
endclass

module tb_skipfield_slot_pool;
    import ssp_pkg::*;

    // Watchdog: a cfg write triggers a clearing pass, a clear command
    // another, and a long receiver hold-off adds its own idle stretch.
    localparam int IDLE_LIMIT = 20000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;

    // Idle percentages, changed per phase by the main sequence.
    int                src_idle_pct = 0;
    int                snk_stall_pct = 0;
    bit                hold_off = 1'b0;
    int                idle_cycles = 0;
    pool_scoreboard    sb;

    always #2 clk = ~clk;

    skipfield_slot_pool i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Receiver: stall at random, or hold off entirely during the pressure
    // stretch; check every accepted result beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
            m_tready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog: count cycles with no beat accepted anywhere.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_skipfield_slot_pool: FAIL");
            $finish;
        end
    end

    // Offer one command beat; hold it until accepted, idling before it at
    // the current sender rate. Note it in the scoreboard on acceptance.
    // Valid stays up after the accept so that a following beat replaces it
    // in the same step; idling or drain() drops it.
    task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] dv,
                            input logic [2:0] hb, input logic [5:0] hs);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, hs, hb, dv, cmd};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_command({4'b0, hs, hb, dv, cmd});
    endtask

    // Drop the sender, drain every outstanding result, then pause for the
    // busy tail.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Write block_size while idle; the model reseeds the pool.
    task automatic write_size(input logic [6:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_size(v);
    endtask

    // Random command mix biased toward handles within or just past the open blocks and block size.
    task automatic random_cmd();
        int          r;
        logic [2:0]  hb;
        logic [5:0]  hs;
        r  = $urandom_range(99);
        hb = $urandom_range(sb.fill);
        hs = $urandom_range(sb.bsize);
        if ($urandom_range(9) == 0)
        begin
            hb = $urandom;
            hs = $urandom;
        end
        if (r < 40)      send_cmd(CMD_INSERT, $urandom, 3'd0, 6'd0);
        else if (r < 60) send_cmd(CMD_ERASE, $urandom, hb, hs);
        else if (r < 72) send_cmd(CMD_GET, $urandom, hb, hs);
        else if (r < 76) send_cmd(CMD_WALK_BEGIN, $urandom, hb, hs);
        else if (r < 96) send_cmd(CMD_WALK_NEXT, $urandom, hb, hs);
        else if (r < 97) send_cmd(CMD_CLEAR, $urandom, hb, hs);
        else             send_cmd(3'd6 + r[0], $urandom, hb, hs);
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes of the fields, every command, bad handles,
        // walk exhausted, unknown commands, clear with a stale walk.
        send_cmd(CMD_WALK_NEXT, 32'h0, 3'd0, 6'd0);
        send_cmd(CMD_INSERT, 32'hFFFF_FFFF, 3'd0, 6'd0);
        send_cmd(CMD_INSERT, 32'h0000_0000, 3'd7, 6'd63);
        send_cmd(CMD_INSERT, 32'hA5A5_5A5A, 3'd0, 6'd0);
        send_cmd(CMD_GET, 32'h0, 3'd0, 6'd0);
        send_cmd(CMD_GET, 32'h0, 3'd7, 6'd63);
        send_cmd(CMD_ERASE, 32'h0, 3'd0, 6'd1);
        send_cmd(CMD_ERASE, 32'h0, 3'd0, 6'd1);
        send_cmd(CMD_GET, 32'h0, 3'd0, 6'd1);
        send_cmd(CMD_WALK_BEGIN, 32'h0, 3'd0, 6'd0);
        send_cmd(CMD_WALK_NEXT, 32'h0, 3'd0, 6'd0);
        send_cmd(CMD_ERASE, 32'h0, 3'd0, 6'd2);
        send_cmd(CMD_WALK_NEXT, 32'h0, 3'd0, 6'd0);
        send_cmd(CMD_WALK_NEXT, 32'h0, 3'd0, 6'd0);
        send_cmd(3'd6, 32'hFFFF_FFFF, 3'd7, 6'd63);
        send_cmd(3'd7, 32'h0, 3'd0, 6'd0);
        send_cmd(CMD_INSERT, 32'h1234_5678, 3'd0, 6'd0);
        send_cmd(CMD_CLEAR, 32'h0, 3'd0, 6'd0);
        send_cmd(CMD_WALK_NEXT, 32'h0, 3'd0, 6'd0);

        // Smallest block: fill all 8 blocks of 16 and overflow the pool.
        write_size(7'd0);
        for (int i = 0; i < 130; i++) send_cmd(CMD_INSERT, $urandom, 3'd0, 6'd0);
        send_cmd(CMD_ERASE, 32'h0, 3'd7, 6'd15);
        send_cmd(CMD_ERASE, 32'h0, 3'd7, 6'd16);
        send_cmd(CMD_WALK_BEGIN, 32'h0, 3'd0, 6'd0);
        for (int i = 0; i < 20; i++) send_cmd(CMD_WALK_NEXT, 32'h0, 3'd0, 6'd0);

        // Pressure: receiver holds off while the sender keeps offering.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 10; i++) random_cmd();
        join

        // Random phases across sizes and idle mixes.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 78;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    snk_stall_pct = 78;
                end
                default:
                begin
                    src_idle_pct = 9;
                    snk_stall_pct = 9;
                end
            endcase
            case (ph)
                0: write_size(7'd127);
                2: write_size(7'd64);
                4: write_size(7'd17);
                6: write_size($urandom_range(16, 63));
                default: ;
            endcase
            for (int i = 0; i < 75; i++) random_cmd();
        end

        src_idle_pct = 0;
        snk_stall_pct = 0;
        drain();
        if (sb.errors == 0)
            $display("tb_skipfield_slot_pool: PASS");
        else
            $display("tb_skipfield_slot_pool: FAIL");
        $finish;
    end
endmodule
